FILE: src/cmmu_pkg.sv
// Shared types, constants and helper functions for the clock-model Metropolis update block.
// Every other file of the block imports this package; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmmu_pkg;

  // Lattice geometry: SIDE must be a power of two no wider than the 6-bit coordinate fields.
  localparam int unsigned SIDE      = 64;
  localparam int unsigned COORD_W   = $clog2(SIDE);
  localparam int unsigned LAT_DEPTH = SIDE * SIDE;
  localparam int unsigned LAT_AW    = 2 * COORD_W;
  localparam int unsigned SPIN_W    = 3;
  localparam int unsigned STATES    = 6;

  localparam int unsigned DRAW_BITS = 16;
  localparam int unsigned THR_W     = DRAW_BITS + 1;
  localparam int unsigned THR_DEPTH = 33;
  localparam int unsigned THR_AW    = $clog2(THR_DEPTH);
  localparam logic [THR_W-1:0] THR_MAX = THR_W'(1) << DRAW_BITS;

  // Energy change in half units spans -16..16.
  localparam int unsigned DE_W = 6;
  localparam logic [DE_W-1:0] DE_BIAS = DE_W'(16);

  localparam logic [SPIN_W-1:0] RESET_SPIN = SPIN_W'(1);

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [5:0]  site_x;
    logic [5:0]  site_y;
    logic [2:0]  new_spin;
    logic [15:0] random_draw;
    logic [5:0]  table_index;
    logic [16:0] table_value;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  spin_read;
    logic [31:0] accept_count;
  } out_t;

  // Controls from the sequencer to the energy accumulator.
  typedef struct packed {
    logic clear;
    logic load_old;
    logic add;
  } de_ctl_t;

  // Twice the cosine of 2*pi*k/6.
  function automatic logic signed [2:0] half_cos(input logic [2:0] k);
    logic signed [2:0] r;
    unique case (k)
      3'd0:    r = 3'sd2;
      3'd1:    r = 3'sd1;
      3'd2:    r = -3'sd1;
      3'd3:    r = -3'sd2;
      3'd4:    r = -3'sd1;
      3'd5:    r = 3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] bond(input logic [SPIN_W-1:0] a,
                                             input logic [SPIN_W-1:0] b);
    logic [3:0] t;
    t = {1'b0, a} + 4'd6 - {1'b0, b};
    if (t >= 4'd6) begin
      t = t - 4'd6;
    end
    return half_cos(t[2:0]);
  endfunction

  // Spins 6 and 7 fold back onto 0 and 1.
  function automatic logic [SPIN_W-1:0] norm_spin(input logic [2:0] s);
    logic [SPIN_W-1:0] r;
    if (s >= 3'd6) begin
      r = SPIN_W'(s - 3'd6);
    end else begin
      r = SPIN_W'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/cmmu_lattice.sv
// Single-port lattice spin memory with registered read data.
// Depends on cmmu_pkg for the lattice depth and spin width.
`timescale 1ns / 1ps
`default_nettype none

module cmmu_lattice
  import cmmu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [LAT_AW-1:0] addr_i,
  input  wire logic [SPIN_W-1:0] wdata_i,
  output logic      [SPIN_W-1:0] rdata_o
);

  logic [SPIN_W-1:0] mem [LAT_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

FILE: src/cmmu_thresh.sv
// Acceptance threshold table: 33 entries, saturated on write, registered read.
// Depends on cmmu_pkg for the table depth and threshold width.
`timescale 1ns / 1ps
`default_nettype none

module cmmu_thresh
  import cmmu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [THR_AW-1:0] addr_i,
  input  wire logic [16:0]       wdata_i,
  output logic      [THR_W-1:0]  rdata_o
);

  logic [THR_W-1:0] mem [THR_DEPTH];
  logic [THR_W-1:0] wsat;

  always_comb begin
    if (wdata_i > 17'(THR_MAX)) begin
      wsat = THR_MAX;
    end else begin
      wsat = THR_W'(wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wsat;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

FILE: src/cmmu_de_unit.sv
// Shared energy-change accumulator: one neighbor bond difference is added per cycle while the add control is high.
// Depends on cmmu_pkg for the cosine ROM, spin width and control struct.
`timescale 1ns / 1ps
`default_nettype none

module cmmu_de_unit
  import cmmu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire de_ctl_t           ctl_i,
  input  wire logic [SPIN_W-1:0] rd_spin_i,
  input  wire logic [SPIN_W-1:0] new_spin_i,
  output logic      [SPIN_W-1:0] old_spin_o,
  output logic      [DE_W-1:0]   de_idx_o
);

  logic signed [DE_W-1:0] acc_q, acc_d;
  logic [SPIN_W-1:0]      old_q;
  logic signed [3:0]      diff;

  assign diff = 4'(bond(old_q, rd_spin_i)) - 4'(bond(new_spin_i, rd_spin_i));

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + DE_W'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_old) begin
      old_q <= rd_spin_i;
    end
  end

  assign old_spin_o = old_q;
  assign de_idx_o   = $unsigned(acc_q) + DE_BIAS;

endmodule

`default_nettype wire

FILE: src/clock_model_metropolis_update.sv
// Top level of the 6-state clock-model Metropolis update block: sequencer, counter, results.
// Depends on cmmu_pkg, cmmu_lattice, cmmu_thresh and cmmu_de_unit.
//
// Usage: a command word is taken on item_i at a rising edge where start_i is high and
// busy_o is low. Each command yields exactly one result word on result_o, shown for one
// cycle with done_o high; the receiver cannot stall, so it must take it in that cycle.
// busy_o falls in the cycle the result is shown, so the next command can start there.
// An update passes through S_READ, S_LOOK and S_DECIDE; a spin write through S_WRITE;
// a spin read or a threshold load through S_RDADR and S_RDDAT.
// The update time is set by the single-port lattice memory: five reads (the site and
// its four wrapped neighbors) one per cycle, then a threshold read, then the decision
// cycle, which also writes the accepted spin back.
// After reset the block sweeps all 4096 lattice sites to spin 1, one site per cycle;
// busy_o stays high during the sweep. The acceptance count resets to zero and
// the threshold table must be loaded before updates rely on it.
`timescale 1ns / 1ps
`default_nettype none

module clock_model_metropolis_update
  import cmmu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire in_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output out_t      result_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_LOOK   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_RDADR  = 3'd6;
  localparam logic [2:0] S_RDDAT  = 3'd7;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic [LAT_AW-1:0]  clr_q, clr_d;
  logic [31:0]        cnt_q, cnt_d;
  logic               done_q, done_d;
  out_t               res_q, res_d;

  logic [COORD_W-1:0]   x_q, y_q;
  logic [SPIN_W-1:0]    spin_q;
  logic [DRAW_BITS-1:0] draw_q;

  logic               take;
  logic               lat_we;
  logic [LAT_AW-1:0]  lat_addr, nb_addr;
  logic [SPIN_W-1:0]  lat_wdata, lat_rdata;
  logic               thr_we;
  logic [THR_AW-1:0]  thr_addr;
  logic [THR_W-1:0]   thr_rdata;
  de_ctl_t            de_ctl;
  logic [SPIN_W-1:0]  old_spin;
  logic [DE_W-1:0]    de_idx;
  logic               accept;

  assign busy_o = (state_q != S_IDLE);
  assign take   = start_i && !busy_o;
  assign accept = (thr_rdata > {1'b0, draw_q});

  cmmu_lattice u_lattice (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .addr_i  (lat_addr),
    .wdata_i (lat_wdata),
    .rdata_o (lat_rdata)
  );

  cmmu_thresh u_thresh (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .addr_i  (thr_addr),
    .wdata_i (item_i.table_value),
    .rdata_o (thr_rdata)
  );

  cmmu_de_unit u_de (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (de_ctl),
    .rd_spin_i  (lat_rdata),
    .new_spin_i (spin_q),
    .old_spin_o (old_spin),
    .de_idx_o   (de_idx)
  );

  // Read order: the site itself, then its right, upper, left and lower neighbors.
  always_comb begin
    unique case (step_q)
      3'd1:    nb_addr = {x_q + COORD_W'(1), y_q};
      3'd2:    nb_addr = {x_q, y_q + COORD_W'(1)};
      3'd3:    nb_addr = {x_q - COORD_W'(1), y_q};
      3'd4:    nb_addr = {x_q, y_q - COORD_W'(1)};
      default: nb_addr = {x_q, y_q};
    endcase
  end

  // The threshold port is loaded straight from the command word; updates index by dE.
  assign thr_we   = take && (item_i.opcode == OP_LOAD) &&
                    (item_i.table_index < 6'(THR_DEPTH));
  assign thr_addr = (state_q == S_IDLE) ? THR_AW'(item_i.table_index) : de_idx;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    res_d     = res_q;
    lat_we    = 1'b0;
    lat_addr  = {x_q, y_q};
    lat_wdata = spin_q;
    de_ctl    = '0;

    unique case (state_q)
      S_CLEAR: begin
        lat_we    = 1'b1;
        lat_addr  = clr_q;
        lat_wdata = RESET_SPIN;
        clr_d     = clr_q + LAT_AW'(1);
        if (clr_q == LAT_AW'(LAT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          step_d = '0;
          unique case (item_i.opcode)
            OP_UPDATE: begin
              state_d      = S_READ;
              de_ctl.clear = 1'b1;
            end
            OP_WRITE: state_d = S_WRITE;
            OP_READ:  state_d = S_RDADR;
            OP_LOAD:  state_d = S_RDADR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        lat_addr = nb_addr;
        step_d   = step_q + 3'd1;
        // Read data arrives in the cycle after its address: the site's own spin comes first.
        if (step_q == 3'd1) begin
          de_ctl.load_old = 1'b1;
        end else if (step_q != 3'd0) begin
          de_ctl.add = 1'b1;
        end
        if (step_q == LAST_STEP) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        lat_we = accept;
        if (accept && (cnt_q != '1)) begin
          cnt_d = cnt_q + 32'd1;
        end
        res_d.accepted     = accept;
        res_d.spin_read    = accept ? spin_q : old_spin;
        res_d.accept_count = cnt_d;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      S_WRITE: begin
        lat_we             = 1'b1;
        res_d.accepted     = 1'b0;
        res_d.spin_read    = spin_q;
        res_d.accept_count = cnt_q;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      S_RDADR: begin
        state_d = S_RDDAT;
      end
      S_RDDAT: begin
        res_d.accepted     = 1'b0;
        res_d.spin_read    = lat_rdata;
        res_d.accept_count = cnt_q;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= '0;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (take) begin
      x_q    <= item_i.site_x[COORD_W-1:0];
      y_q    <= item_i.site_y[COORD_W-1:0];
      spin_q <= norm_spin(item_i.new_spin);
      draw_q <= item_i.random_draw[DRAW_BITS-1:0];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while the block is still busy");

  a_accept_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.accepted) |-> (result_o.accept_count != 32'd0))
    else $error("accepted update reported with a zero count");

  a_count_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_DECIDE))
    else $error("acceptance count changed outside a decision cycle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 32'd1))
    else $error("acceptance count moved by other than one");
`endif

endmodule

`default_nettype wire
